// ----- rtl/sliding_window_volatility_macros.svh -----
// assertion macros for the volatility block checker
// needs clk and arst_n in the scope where used
`ifndef SLIDING_WINDOW_VOLATILITY_MACROS_SVH
`define SLIDING_WINDOW_VOLATILITY_MACROS_SVH

// same-cycle implication
`define SWV_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swv check failed");

// next-cycle implication
`define SWV_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swv check failed");

`endif

// ----- rtl/swv_pkg.sv -----
// shared types and constants of the sliding window volatility block
// no dependencies
package swv_pkg;

	localparam int WINDOW_MAX_DEF = 256;
	localparam int WL_W           = 9;
	localparam int WL_RESET       = 20;
	localparam int PRICE_W        = 32;
	localparam int CHANGE_W       = 32;
	localparam int FRAC_RATIO     = 28;
	localparam int FIFO_DEPTH     = 4;
	localparam int SQ_STEPS       = 28;

	localparam logic [31:0] ONE_Q28    = 32'h1000_0000;
	localparam logic [31:0] CHANGE_MAX = 32'h7FFF_FFFF;
	localparam logic [59:0] RATIO_SAT  = 60'h0_8FFF_FFFF;
	localparam logic [31:0] ANNUAL_K   = 32'd266330047;

	typedef struct packed {
		logic                start;
		logic                sat;
		logic [CHANGE_W-1:0] change;
	} swv_item_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_SQN,
		B_SQO,
		B_UPD,
		B_D2S,
		B_D2W,
		B_D1S,
		B_D1W,
		B_MM,
		B_VAR,
		B_SQRT,
		B_MULK,
		B_OUT
	} back_state_t;

endpackage

// ----- rtl/swv_divu.sv -----
// unsigned restoring divider, one quotient bit per cycle
// no dependencies
module swv_divu #(
	parameter int NUM_W = 60,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] sh_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, sh_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			sh_q  <= {sh_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = sh_q;

endmodule

// ----- rtl/swv_front.sv -----
// front end: takes price words, forms the relative change
// depends on swv_pkg and swv_divu
module swv_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clr,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [swv_pkg::PRICE_W-1:0]   price,
	input  logic                          series_start,
	output logic                          push_valid,
	input  logic                          push_ready,
	output swv_pkg::swv_item_t            push_item
);

	localparam int NUM_W = swv_pkg::PRICE_W + swv_pkg::FRAC_RATIO;

	swv_pkg::front_state_t state_q, state_d;
	logic [swv_pkg::PRICE_W-1:0] prev_q;
	logic                        active_q;
	swv_pkg::swv_item_t          item_q;
	logic                        accept;
	logic                        direct;
	logic                        div_start;
	logic                        div_done;
	logic [NUM_W-1:0]            div_quo;

	assign accept = in_valid && in_ready;
	assign direct = series_start || !active_q || (prev_q == '0);

	swv_divu #(
		.NUM_W(NUM_W),
		.DEN_W(swv_pkg::PRICE_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   ({price, swv_pkg::FRAC_RATIO'(0)}),
		.den   (prev_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			swv_pkg::F_IDLE: begin
				if (accept)
					state_d = direct ? swv_pkg::F_PUSH : swv_pkg::F_DIV;
			end
			swv_pkg::F_DIV: begin
				if (div_done)
					state_d = swv_pkg::F_PUSH;
			end
			swv_pkg::F_PUSH: begin
				if (push_ready)
					state_d = swv_pkg::F_IDLE;
			end
			default: state_d = swv_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == swv_pkg::F_IDLE);
		push_valid = (state_q == swv_pkg::F_PUSH);
		div_start  = accept && !direct;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= swv_pkg::F_IDLE;
			active_q <= 1'b0;
			prev_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clr)
				active_q <= 1'b0;
			else if (accept)
				active_q <= 1'b1;
			if (accept)
				prev_q <= price;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && direct) begin
			if (series_start || !active_q) begin
				item_q.start  <= 1'b1;
				item_q.sat    <= 1'b0;
				item_q.change <= '0;
			end else begin
				item_q.start  <= 1'b0;
				item_q.sat    <= 1'b1;
				item_q.change <= swv_pkg::CHANGE_MAX;
			end
		end else if (state_q == swv_pkg::F_DIV && div_done) begin
			item_q.start <= 1'b0;
			if (div_quo >= swv_pkg::RATIO_SAT) begin
				item_q.sat    <= 1'b1;
				item_q.change <= swv_pkg::CHANGE_MAX;
			end else begin
				item_q.sat    <= 1'b0;
				item_q.change <= div_quo[31:0] - swv_pkg::ONE_Q28;
			end
		end
	end

	assign push_item = item_q;

endmodule

// ----- rtl/swv_fifo.sv -----
// short queue of classified changes between front and back
// depends on swv_pkg
module swv_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  swv_pkg::swv_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output swv_pkg::swv_item_t pop_item
);

	localparam int PTR_W = $clog2(swv_pkg::FIFO_DEPTH);
	localparam int CNT_W = $clog2(swv_pkg::FIFO_DEPTH + 1);

	swv_pkg::swv_item_t mem_q [swv_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != CNT_W'(swv_pkg::FIFO_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PTR_W'(swv_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (do_pop)
				rd_q <= (rd_q == PTR_W'(swv_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_item;
	end

endmodule

// ----- rtl/swv_back.sv -----
// back end: change ring, running sums, mean, variance, root and scaling
// depends on swv_pkg and swv_divu
module swv_back #(
	parameter int WINDOW_MAX = swv_pkg::WINDOW_MAX_DEF,
	parameter int NW         = $clog2(WINDOW_MAX + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [NW-1:0]      n,
	input  logic               item_valid,
	output logic               item_ready,
	input  swv_pkg::swv_item_t item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        volatility,
	output logic               saturated
);

	localparam int PW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int SW    = $clog2(WINDOW_MAX + 2);
	localparam int AW    = $clog2(2 * WINDOW_MAX);
	localparam int CT_W  = 33 + PW;
	localparam int ST_W  = 40 + PW;
	localparam int SQ_CW = $clog2(swv_pkg::SQ_STEPS + 1);

	swv_pkg::back_state_t state_q, state_d;

	logic [31:0]       ring [WINDOW_MAX];
	logic [31:0]       old_q;
	logic [SW-1:0]     seen_q;
	logic [PW-1:0]     pos_q;
	logic signed [CT_W-1:0] ct_q;
	logic [ST_W-1:0]   st_q;
	logic [31:0]       craw_q;
	logic              satc_q;
	logic              full_q;
	logic              emit_q;
	logic [39:0]       sqn_q;
	logic [39:0]       m2_q;
	logic [31:0]       mean_q;
	logic [63:0]       prod_q;
	logic [55:0]       rad_q;
	logic [28:0]       srem_q;
	logic [27:0]       root_q;
	logic [SQ_CW-1:0]  scnt_q;
	logic              ov_q;
	logic [31:0]       vol_q;
	logic              sat_q;

	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic              div_start;
	logic [ST_W-1:0]   div_num;
	logic              div_done;
	logic [ST_W-1:0]   div_quo;
	logic [AW-1:0]     old_sum;
	logic [PW-1:0]     old_addr;
	logic              full_now;
	logic [39:0]       sqo;
	logic [39:0]       mm;
	logic [39:0]       var_v;
	logic [CT_W-1:0]   ct_abs;
	logic [30:0]       rem2;
	logic [30:0]       sub;
	logic              sq_ge;
	logic [56:0]       rnd;
	logic              pop;

	function automatic logic [31:0] mag32(input logic [31:0] x);
		mag32 = x[31] ? (~x + 32'd1) : x;
	endfunction

	assign old_sum  = AW'(pos_q) + AW'(WINDOW_MAX) - AW'(n);
	assign old_addr = (old_sum >= AW'(WINDOW_MAX)) ?
		PW'(old_sum - AW'(WINDOW_MAX)) : PW'(old_sum);
	assign full_now = (seen_q - SW'(1)) >= SW'(n);
	assign sqo      = prod_q[63:24];
	assign mm       = prod_q[63:24];
	assign var_v    = (m2_q > mm) ? (m2_q - mm) : '0;
	assign ct_abs   = ct_q[CT_W-1] ? CT_W'(-ct_q) : CT_W'(ct_q);
	assign rem2     = {srem_q, rad_q[55:54]};
	assign sub      = {1'b0, root_q, 2'b01};
	assign sq_ge    = rem2 >= sub;
	assign rnd      = {1'b0, prod_q[55:0]} + 57'(1 << 23);
	assign pop      = item_valid && item_ready;

	swv_divu #(
		.NUM_W(ST_W),
		.DEN_W(NW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (n),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			swv_pkg::B_IDLE: begin
				if (item_valid && !item.start)
					state_d = swv_pkg::B_SQN;
			end
			swv_pkg::B_SQN:  state_d = swv_pkg::B_SQO;
			swv_pkg::B_SQO:  state_d = swv_pkg::B_UPD;
			swv_pkg::B_UPD:  state_d = emit_q ? swv_pkg::B_D2S : swv_pkg::B_IDLE;
			swv_pkg::B_D2S:  state_d = swv_pkg::B_D2W;
			swv_pkg::B_D2W: begin
				if (div_done)
					state_d = swv_pkg::B_D1S;
			end
			swv_pkg::B_D1S:  state_d = swv_pkg::B_D1W;
			swv_pkg::B_D1W: begin
				if (div_done)
					state_d = swv_pkg::B_MM;
			end
			swv_pkg::B_MM:   state_d = swv_pkg::B_VAR;
			swv_pkg::B_VAR:  state_d = swv_pkg::B_SQRT;
			swv_pkg::B_SQRT: begin
				if (scnt_q == SQ_CW'(1))
					state_d = swv_pkg::B_MULK;
			end
			swv_pkg::B_MULK: state_d = swv_pkg::B_OUT;
			swv_pkg::B_OUT: begin
				if (!ov_q || out_ready)
					state_d = swv_pkg::B_IDLE;
			end
			default: state_d = swv_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		item_ready = (state_q == swv_pkg::B_IDLE);
		div_start  = (state_q == swv_pkg::B_D2S) || (state_q == swv_pkg::B_D1S);
		div_num    = (state_q == swv_pkg::B_D2S) ? st_q : ST_W'(ct_abs);
		mul_a      = '0;
		mul_b      = '0;
		case (state_q)
			swv_pkg::B_SQN: begin
				mul_a = mag32(craw_q);
				mul_b = mag32(craw_q);
			end
			swv_pkg::B_SQO: begin
				mul_a = mag32(old_q);
				mul_b = mag32(old_q);
			end
			swv_pkg::B_MM: begin
				mul_a = mean_q;
				mul_b = mean_q;
			end
			swv_pkg::B_MULK: begin
				mul_a = 32'(root_q);
				mul_b = swv_pkg::ANNUAL_K;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swv_pkg::B_IDLE;
			seen_q  <= '0;
			pos_q   <= '0;
			ct_q    <= '0;
			st_q    <= '0;
			scnt_q  <= '0;
			ov_q    <= 1'b0;
			emit_q  <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && item.start) begin
				seen_q <= SW'(1);
				pos_q  <= '0;
				ct_q   <= '0;
				st_q   <= '0;
			end else if (pop) begin
				full_q <= full_now;
				emit_q <= full_now || (seen_q == SW'(n));
			end
			if (state_q == swv_pkg::B_UPD) begin
				ct_q <= ct_q + CT_W'($signed(craw_q))
					- (full_q ? CT_W'($signed(old_q)) : CT_W'(0));
				st_q <= st_q + ST_W'(sqn_q) - (full_q ? ST_W'(sqo) : ST_W'(0));
				pos_q <= (pos_q == PW'(WINDOW_MAX - 1)) ? '0 : pos_q + PW'(1);
				if (!full_q)
					seen_q <= seen_q + SW'(1);
			end
			if (state_q == swv_pkg::B_VAR)
				scnt_q <= SQ_CW'(swv_pkg::SQ_STEPS);
			else if (state_q == swv_pkg::B_SQRT)
				scnt_q <= scnt_q - SQ_CW'(1);
			if (state_q == swv_pkg::B_OUT && (!ov_q || out_ready))
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !item.start) begin
			old_q  <= ring[old_addr];
			craw_q <= item.change;
			satc_q <= item.sat;
		end
		if (state_q == swv_pkg::B_UPD)
			ring[pos_q] <= craw_q;
		if (state_q == swv_pkg::B_SQN || state_q == swv_pkg::B_SQO ||
		    state_q == swv_pkg::B_MM || state_q == swv_pkg::B_MULK)
			prod_q <= mul_a * mul_b;
		if (state_q == swv_pkg::B_SQO)
			sqn_q <= prod_q[63:24];
		if (state_q == swv_pkg::B_D2W && div_done)
			m2_q <= div_quo[39:0];
		if (state_q == swv_pkg::B_D1W && div_done)
			mean_q <= div_quo[31:0];
		if (state_q == swv_pkg::B_VAR) begin
			rad_q  <= {var_v, 16'd0};
			srem_q <= '0;
			root_q <= '0;
		end else if (state_q == swv_pkg::B_SQRT) begin
			rad_q  <= {rad_q[53:0], 2'b00};
			srem_q <= sq_ge ? 29'(rem2 - sub) : 29'(rem2);
			root_q <= {root_q[26:0], sq_ge};
		end
		if (state_q == swv_pkg::B_OUT && (!ov_q || out_ready)) begin
			vol_q <= rnd[56] ? 32'hFFFF_FFFF : rnd[55:24];
			sat_q <= satc_q || rnd[56];
		end
	end

	assign out_valid  = ov_q;
	assign volatility = vol_q;
	assign saturated  = sat_q;

endmodule

// ----- rtl/sliding_window_volatility.sv -----
// top level: annualized volatility over a sliding window of price changes
// a price that yields a result passes the front ratio divider, the back divider twice
// (mean of squares, then mean) and 28 root steps; the front takes a new price only
// after it has pushed the last change into the queue
// reset: arst_n clears series state, counters and sums; window length resets to 20
// (at most WINDOW_MAX); the change ring has no reset and is used only when full
module sliding_window_volatility #(
	parameter int WINDOW_MAX = swv_pkg::WINDOW_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [31:0]                s_axis_tdata,  // price
	input  logic                       s_axis_tuser,  // series_start
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [31:0]                m_axis_tdata,  // volatility
	output logic                       m_axis_tuser,  // saturated
	input  logic                       cfg_we,
	input  logic [swv_pkg::WL_W-1:0]   cfg_wdata
);

	localparam int NW      = $clog2(WINDOW_MAX + 1);
	localparam int N_RESET = (swv_pkg::WL_RESET > WINDOW_MAX) ? WINDOW_MAX : swv_pkg::WL_RESET;

	logic [NW-1:0]      n_q;
	logic [NW-1:0]      n_new;
	logic               f_valid;
	logic               f_ready;
	swv_pkg::swv_item_t f_item;
	logic               b_valid;
	logic               b_ready;
	swv_pkg::swv_item_t b_item;

	always_comb begin
		if (cfg_wdata == '0)
			n_new = NW'(1);
		else if (32'(cfg_wdata) > 32'(WINDOW_MAX))
			n_new = NW'(WINDOW_MAX);
		else
			n_new = NW'(cfg_wdata);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			n_q <= NW'(N_RESET);
		else if (cfg_we)
			n_q <= n_new;
	end

	swv_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.clr         (cfg_we),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.price       (s_axis_tdata),
		.series_start(s_axis_tuser),
		.push_valid  (f_valid),
		.push_ready  (f_ready),
		.push_item   (f_item)
	);

	swv_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_item (f_item),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_item  (b_item)
	);

	swv_back #(
		.WINDOW_MAX(WINDOW_MAX),
		.NW        (NW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.n         (n_q),
		.item_valid(b_valid),
		.item_ready(b_ready),
		.item      (b_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.volatility(m_axis_tdata),
		.saturated (m_axis_tuser)
	);

endmodule

// ----- rtl/swv_checker.sv -----
// port-level checks for the volatility block, bound to the top level
// depends on sliding_window_volatility_macros.svh
`include "sliding_window_volatility_macros.svh"

module swv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// stalled result word holds
	`SWV_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// front takes one word, then works on it
	`SWV_ASSERT_NXT(a_in_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// nothing to show right after reset
	`SWV_ASSERT_IMP(a_out_reset, $rose(arst_n), !m_axis_tvalid)

endmodule

bind sliding_window_volatility swv_checker u_swv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
